[hdl/slt_pkg.sv]
package slt_pkg;

	localparam int SLT_DEPTH = 16;
	localparam int VAL_W     = 32;
	localparam int RES_W     = 5;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_SEARCH = 2'd2,
		FN_CLEAR  = 2'd3
	} func_e;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_e;

	typedef struct packed {
		func_e                    func;
		logic signed [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		status_e           status;
		logic [RES_W-1:0]  position;
		logic [RES_W-1:0]  fill;
	} rsp_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_USED,
		IDX_INC,
		IDX_DEC
	} idx_op_e;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_PREV,
		RD_NEXT
	} rd_op_e;

	typedef enum logic [1:0] {
		U_HOLD,
		U_INC,
		U_DEC,
		U_CLR
	} used_op_e;

	typedef struct packed {
		logic      load;
		idx_op_e   idx_op;
		rd_op_e    rd_op;
		logic      wr_en;
		logic      wr_key;
		used_op_e  used_op;
		logic      respond;
		status_e   rsp_status;
		logic      pos_hit;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic idx_zero;
		logic idx_at_used;
		logic idx_last;
		logic lt;
		logic eq;
	} dp_sts_t;

endpackage

[hdl/sorted_list_table.sv]
// Channel   Signals              Handshake
// request   req (func, value)    taken at clk edge with start=1, busy=0
// result    rsp (status,         valid for one cycle while done=1;
//           position, fill)      taken at the edge ending that cycle
//
// One request at a time; done follows the last cycle of the request.
// Clear and a rejected insert answer straight from idle. Insert walks down from
// the top, moving each value not below the key up one slot, then writes the key.
// Search and remove walk up to the first value not below the key; on a match,
// remove moves later values down. Each step is one read of the single RAM read port.
// arst_n empties the table; RAM contents are not cleared. The result side
// cannot stall; busy is high while a request is being worked.
module sorted_list_table #(
	parameter int DEPTH = slt_pkg::SLT_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  slt_pkg::req_t  req,
	output logic           busy,
	output logic           done,
	output slt_pkg::rsp_t  rsp
);

	import slt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	slt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	slt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (req.value),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while request still in progress");

	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither worked nor answered");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.func == FN_CLEAR |=> done && rsp.fill == '0
			&& rsp.status == ST_DONE)
		else $error("clear did not empty the table");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_DONE |-> rsp.position == '0)
		else $error("position reported on failed request");
`endif

endmodule

[hdl/slt_ram.sv]
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/slt_dp.sv]
module slt_dp #(
	parameter int DEPTH = slt_pkg::SLT_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [slt_pkg::VAL_W-1:0]      value,
	input  slt_pkg::dp_cmd_t                      cmd,
	output slt_pkg::dp_sts_t                      sts,
	output slt_pkg::rsp_t                         rsp
);

	import slt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           used_q;
	logic [CW-1:0]           used_nxt;
	logic [CW-1:0]           idx_p1;
	logic [CW-1:0]           idx_m1;
	logic [CW-1:0]           rd_idx;
	logic signed [VAL_W-1:0] key_q;
	logic [VAL_W-1:0]        rdata;
	logic [VAL_W-1:0]        wdata;
	rsp_t                    rsp_q;

	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);

	always_comb begin
		unique case (cmd.rd_op)
			RD_PREV: rd_idx = idx_m1;
			RD_NEXT: rd_idx = idx_p1;
			default: rd_idx = idx_q;
		endcase
	end

	assign wdata = cmd.wr_key ? key_q : rdata;

	slt_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (idx_q[AW-1:0]),
		.wdata (wdata),
		.raddr (rd_idx[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		unique case (cmd.used_op)
			U_INC:   used_nxt = used_q + CW'(1);
			U_DEC:   used_nxt = used_q - CW'(1);
			U_CLR:   used_nxt = '0;
			default: used_nxt = used_q;
		endcase
	end

	assign sts.full        = (used_q == CW'(DEPTH));
	assign sts.idx_zero    = (idx_q == '0);
	assign sts.idx_at_used = (idx_q == used_q);
	assign sts.idx_last    = (idx_p1 == used_q);
	assign sts.lt          = ($signed(rdata) < key_q);
	assign sts.eq          = ($signed(rdata) == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q  <= '0;
		end else begin
			used_q <= used_nxt;
			unique case (cmd.idx_op)
				IDX_ZERO: idx_q <= '0;
				IDX_USED: idx_q <= used_q;
				IDX_INC:  idx_q <= idx_p1;
				IDX_DEC:  idx_q <= idx_m1;
				default:  idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= value;
		end
		if (cmd.respond) begin
			rsp_q.status   <= cmd.rsp_status;
			rsp_q.position <= cmd.pos_hit ? RES_W'(idx_p1) : '0;
			rsp_q.fill     <= RES_W'(used_nxt);
		end
	end

	assign rsp = rsp_q;

endmodule

[hdl/slt_ctrl.sv]
module slt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  slt_pkg::func_e    func,
	input  slt_pkg::dp_sts_t  sts,
	output slt_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);

	import slt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_FND_CHK,
		S_FND_CMP,
		S_SHF_CHK,
		S_SHF_CMP
	} state_t;

	state_t state_q;
	state_t state_nxt;
	func_e  func_q;
	logic   done_q;

	always_comb begin
		cmd        = '{load: 1'b0, idx_op: IDX_HOLD, rd_op: RD_IDX, wr_en: 1'b0,
		               wr_key: 1'b0, used_op: U_HOLD, respond: 1'b0,
		               rsp_status: ST_DONE, pos_hit: 1'b0};
		state_nxt  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (func) inside
						FN_INSERT: begin
							if (sts.full) begin
								cmd.respond    = 1'b1;
								cmd.rsp_status = ST_FULL;
							end else begin
								cmd.idx_op = IDX_USED;
								state_nxt  = S_INS_CHK;
							end
						end
						FN_REMOVE, FN_SEARCH: begin
							cmd.idx_op = IDX_ZERO;
							state_nxt  = S_FND_CHK;
						end
						default: begin
							cmd.used_op = U_CLR;
							cmd.respond = 1'b1;
						end
					endcase
				end
			end
			// walk down from the top, moving values not below the key up one slot
			S_INS_CHK: begin
				if (sts.idx_zero) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_key  = 1'b1;
					cmd.used_op = U_INC;
					cmd.respond = 1'b1;
					state_nxt   = S_IDLE;
				end else begin
					cmd.rd_op = RD_PREV;
					state_nxt = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (!sts.lt) begin
					cmd.idx_op = IDX_DEC;
					state_nxt  = S_INS_CHK;
				end else begin
					cmd.wr_key  = 1'b1;
					cmd.used_op = U_INC;
					cmd.respond = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			S_FND_CHK: begin
				if (sts.idx_at_used) begin
					cmd.respond    = 1'b1;
					cmd.rsp_status = ST_MISSING;
					state_nxt      = S_IDLE;
				end else begin
					state_nxt = S_FND_CMP;
				end
			end
			S_FND_CMP: begin
				if (sts.lt) begin
					cmd.idx_op = IDX_INC;
					state_nxt  = S_FND_CHK;
				end else if (sts.eq) begin
					if (func_q == FN_SEARCH) begin
						cmd.respond = 1'b1;
						cmd.pos_hit = 1'b1;
						state_nxt   = S_IDLE;
					end else begin
						state_nxt = S_SHF_CHK;
					end
				end else begin
					cmd.respond    = 1'b1;
					cmd.rsp_status = ST_MISSING;
					state_nxt      = S_IDLE;
				end
			end
			// close the gap left by the removed value
			S_SHF_CHK: begin
				if (sts.idx_last) begin
					cmd.used_op = U_DEC;
					cmd.respond = 1'b1;
					state_nxt   = S_IDLE;
				end else begin
					cmd.rd_op = RD_NEXT;
					state_nxt = S_SHF_CMP;
				end
			end
			S_SHF_CMP: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = IDX_INC;
				state_nxt  = S_SHF_CHK;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q  <= FN_INSERT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.respond;
			if (cmd.load) begin
				func_q <= func;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
